// ----- design/oct_pkg.sv -----
`default_nettype none
package oct_pkg;

  // Field widths
  localparam int KeyW  = 4;
  localparam int PhW   = 3;
  localparam int MinW  = 7;
  localparam int SecW  = 6;
  localparam int TempW = 8;
  localparam int PreW  = 7;
  localparam int BuzzW = 4;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Operating phases
  typedef enum logic [PhW-1:0] {
    PH_HOME     = 3'd0,
    PH_SET_TIME = 3'd1,
    PH_READY    = 3'd2,
    PH_DONE     = 3'd3,
    PH_SET_TEMP = 3'd4,
    PH_PREHEAT  = 3'd5
  } phase_t;

  // Keypad codes
  localparam logic [KeyW-1:0] KEY_MICRO = 4'd1;
  localparam logic [KeyW-1:0] KEY_GRILL = 4'd2;
  localparam logic [KeyW-1:0] KEY_CONV  = 4'd3;
  localparam logic [KeyW-1:0] KEY_QUICK = 4'd4;
  localparam logic [KeyW-1:0] KEY_INC   = 4'd4;
  localparam logic [KeyW-1:0] KEY_NEXT  = 4'd5;
  localparam logic [KeyW-1:0] KEY_STOP  = 4'd6;
  localparam logic [KeyW-1:0] KEY_DEC   = 4'd7;
  localparam logic [KeyW-1:0] KEY_ENTER = 4'd12;

  // Register indexes (word address)
  localparam logic [2:0] REG_MAX_MIN  = 3'd0;
  localparam logic [2:0] REG_MAX_TEMP = 3'd1;
  localparam logic [2:0] REG_PREHEAT  = 3'd2;
  localparam logic [2:0] REG_QUICK    = 3'd3;
  localparam logic [2:0] REG_BUZZ     = 3'd4;

  // Limits and reset values
  localparam logic [SecW-1:0]  SecLimit      = 6'd59;
  localparam logic [MinW-1:0]  MinCap        = 7'd99;
  localparam logic [MinW-1:0]  MaxMinRst     = 7'd60;
  localparam logic [TempW-1:0] MaxTempRst    = 8'd180;
  localparam logic [PreW-1:0]  PreheatRst    = 7'd60;
  localparam logic [SecW-1:0]  QuickRst      = 6'd30;
  localparam logic [BuzzW-1:0] BuzzRst       = 4'd3;

  typedef struct packed {
    logic [MinW-1:0]  max_minutes;
    logic [TempW-1:0] max_temperature;
    logic [PreW-1:0]  preheat_seconds;
    logic [SecW-1:0]  quick_start_seconds;
    logic [BuzzW-1:0] buzzer_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic             sec_sel;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [TempW-1:0] temp;
    logic [PreW-1:0]  preheat;
    logic             cooking;
    logic [BuzzW-1:0] buzz;
  } state_t;

  function automatic logic [MinW-1:0] cap_min(input logic [MinW-1:0] v);
    return (v > MinCap) ? MinCap : v;
  endfunction

  function automatic logic [SecW-1:0] cap_sec(input logic [SecW-1:0] v);
    return (v > SecLimit) ? SecLimit : v;
  endfunction

endpackage
`default_nettype wire

// ----- design/oct_if.sv -----
`default_nettype none
// Keypad sample channel
interface oct_in_if import oct_pkg::*;;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key_code;
  logic            tick;
  modport source(output valid, key_code, tick, input ready);
  modport sink(input valid, key_code, tick, output ready);
endinterface

// Controller status channel
interface oct_out_if import oct_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PhW-1:0]   phase;
  logic             editing_seconds;
  logic [MinW-1:0]  minutes_left;
  logic [SecW-1:0]  seconds_left;
  logic [TempW-1:0] temperature;
  logic [PreW-1:0]  preheat_left;
  logic             fan_on;
  logic             buzzer_on;
  modport source(output valid, phase, editing_seconds, minutes_left, seconds_left,
                 temperature, preheat_left, fan_on, buzzer_on, input ready);
  modport sink(input valid, phase, editing_seconds, minutes_left, seconds_left,
               temperature, preheat_left, fan_on, buzzer_on, output ready);
endinterface
`default_nettype wire

// ----- design/oct_cfg.sv -----
`default_nettype none
module oct_cfg import oct_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [2:0] idx;
  cfg_t       cfg_r;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[AddrW-1:2];
  assign cfg   = cfg_r;

  // Register writes, access phase only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_minutes         <= MaxMinRst;
      cfg_r.max_temperature     <= MaxTempRst;
      cfg_r.preheat_seconds     <= PreheatRst;
      cfg_r.quick_start_seconds <= QuickRst;
      cfg_r.buzzer_ticks        <= BuzzRst;
    end else if (wr_en) begin
      case (idx)
        REG_MAX_MIN:  cfg_r.max_minutes         <= pwdata[MinW-1:0];
        REG_MAX_TEMP: cfg_r.max_temperature     <= pwdata[TempW-1:0];
        REG_PREHEAT:  cfg_r.preheat_seconds     <= pwdata[PreW-1:0];
        REG_QUICK:    cfg_r.quick_start_seconds <= pwdata[SecW-1:0];
        REG_BUZZ:     cfg_r.buzzer_ticks        <= pwdata[BuzzW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_MAX_MIN:  prdata = {{(DataW-MinW){1'b0}}, cfg_r.max_minutes};
      REG_MAX_TEMP: prdata = {{(DataW-TempW){1'b0}}, cfg_r.max_temperature};
      REG_PREHEAT:  prdata = {{(DataW-PreW){1'b0}}, cfg_r.preheat_seconds};
      REG_QUICK:    prdata = {{(DataW-SecW){1'b0}}, cfg_r.quick_start_seconds};
      REG_BUZZ:     prdata = {{(DataW-BuzzW){1'b0}}, cfg_r.buzzer_ticks};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/oven_cook_timer_controller.sv -----
`default_nettype none
// Channel   Dir   Handshake       Payload
// in_ch     in    valid/ready     key_code[3:0], tick
// out_ch    out   valid/ready     phase, editing_seconds, minutes_left, seconds_left,
//                                 temperature, preheat_left, fan_on, buzzer_on
// cfg_*     in    APB write/read  five 32-bit registers at byte address 4*i
//
// One item per clock sustained while the output is not stalled.
// Stage 1 registers the keypad sample; the phase/counter update runs in one
// combinational step between it and the result register.
// Synchronous active-low reset returns to home with counters cleared and preheat at its reset value.
// A stalled output holds the result; the input stage accepts while it is empty or
// while its sample moves into a result register that is free or drained in that cycle.
module oven_cook_timer_controller import oct_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  oct_in_if.sink                in_ch,
  oct_out_if.source             out_ch,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [AddrW-1:0] cfg_paddr,
  input  wire logic [DataW-1:0] cfg_pwdata,
  output logic      [DataW-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t            cfg;
  logic            s1_valid_r;
  logic [KeyW-1:0] s1_key_r;
  logic            s1_tick_r;
  logic            out_valid_r;
  logic            advance;
  state_t          state_r, state_nxt;

  assign cfg_pready = 1'b1;

  oct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Pipeline flow control
  assign advance     = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_key_r  <= in_ch.key_code;
      s1_tick_r <= in_ch.tick;
    end
  end

  // Phase and counter update for one keypad sample
  always_comb begin
    state_nxt = state_r;
    case (state_r.phase)
      PH_SET_TIME: begin
        if (!state_r.sec_sel) begin
          if (s1_key_r == KEY_INC) begin
            if (state_r.minutes < cap_min(cfg.max_minutes))
              state_nxt.minutes = state_r.minutes + 7'd1;
          end else if (s1_key_r == KEY_DEC) begin
            if (state_r.minutes != '0) state_nxt.minutes = state_r.minutes - 7'd1;
          end else if (s1_key_r == KEY_NEXT) begin
            state_nxt.sec_sel = 1'b1;
          end
        end else begin
          if (s1_key_r == KEY_INC) begin
            if (state_r.seconds < SecLimit) state_nxt.seconds = state_r.seconds + 6'd1;
          end else if (s1_key_r == KEY_DEC) begin
            if (state_r.seconds != '0) state_nxt.seconds = state_r.seconds - 6'd1;
          end else if (s1_key_r == KEY_ENTER) begin
            state_nxt.phase = PH_READY;
          end
        end
      end
      PH_READY: begin
        // keys first, then the countdown sees the updated cooking flag
        if (s1_key_r == KEY_INC) begin
          state_nxt.cooking = 1'b1;
        end else if (s1_key_r == KEY_NEXT) begin
          state_nxt.cooking = 1'b0;
        end else if (s1_key_r == KEY_STOP) begin
          state_nxt.cooking = 1'b0;
          state_nxt.minutes = '0;
          state_nxt.seconds = '0;
          state_nxt.sec_sel = 1'b0;
          state_nxt.phase   = PH_HOME;
        end
        if (s1_tick_r && state_nxt.cooking) begin
          if (state_r.seconds != '0) begin
            state_nxt.seconds = state_r.seconds - 6'd1;
          end else if (state_r.minutes != '0) begin
            state_nxt.minutes = state_r.minutes - 7'd1;
            state_nxt.seconds = SecLimit;
          end else begin
            state_nxt.cooking = 1'b0;
            state_nxt.buzz    = cfg.buzzer_ticks;
            state_nxt.phase   = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        if (state_r.buzz == '0 || (s1_tick_r && state_r.buzz == 4'd1)) begin
          if (state_r.buzz != '0) state_nxt.buzz = '0;
          state_nxt.minutes = '0;
          state_nxt.seconds = '0;
          state_nxt.sec_sel = 1'b0;
          state_nxt.cooking = 1'b0;
          state_nxt.phase   = PH_HOME;
        end else if (s1_tick_r) begin
          state_nxt.buzz = state_r.buzz - 4'd1;
        end
      end
      PH_SET_TEMP: begin
        if (s1_key_r == KEY_INC) begin
          if (state_r.temp < cfg.max_temperature) state_nxt.temp = state_r.temp + 8'd1;
        end else if (s1_key_r == KEY_DEC) begin
          if (state_r.temp != '0) state_nxt.temp = state_r.temp - 8'd1;
        end else if (s1_key_r == KEY_ENTER) begin
          state_nxt.preheat = cap_min(cfg.preheat_seconds);
          state_nxt.phase   = PH_PREHEAT;
        end
      end
      PH_PREHEAT: begin
        if (s1_tick_r) begin
          if (state_r.preheat != '0) begin
            state_nxt.preheat = state_r.preheat - 7'd1;
          end else begin
            state_nxt.minutes = '0;
            state_nxt.seconds = '0;
            state_nxt.sec_sel = 1'b0;
            state_nxt.phase   = PH_SET_TIME;
          end
        end
      end
      default: begin
        // home, and any unused phase code
        state_nxt.phase = PH_HOME;
        if (s1_key_r == KEY_MICRO) begin
          state_nxt.phase = PH_SET_TIME;
        end else if (s1_key_r == KEY_GRILL) begin
          state_nxt.minutes = '0;
          state_nxt.seconds = '0;
          state_nxt.sec_sel = 1'b0;
          state_nxt.phase   = PH_SET_TIME;
        end else if (s1_key_r == KEY_CONV) begin
          state_nxt.temp  = '0;
          state_nxt.phase = PH_SET_TEMP;
        end else if (s1_key_r == KEY_QUICK) begin
          state_nxt.minutes = '0;
          state_nxt.seconds = cap_sec(cfg.quick_start_seconds);
          state_nxt.cooking = 1'b1;
          state_nxt.phase   = PH_READY;
        end
      end
    endcase
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase   <= PH_HOME;
      state_r.sec_sel <= 1'b0;
      state_r.minutes <= '0;
      state_r.seconds <= '0;
      state_r.temp    <= '0;
      state_r.preheat <= PreheatRst;
      state_r.cooking <= 1'b0;
      state_r.buzz    <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.phase           <= state_nxt.phase;
      out_ch.editing_seconds <= (state_nxt.phase == PH_SET_TIME) & state_nxt.sec_sel;
      out_ch.minutes_left    <= state_nxt.minutes;
      out_ch.seconds_left    <= state_nxt.seconds;
      out_ch.temperature     <= state_nxt.temp;
      out_ch.preheat_left    <= state_nxt.preheat;
      out_ch.fan_on          <= state_nxt.cooking;
      out_ch.buzzer_on       <= (state_nxt.phase == PH_DONE);
    end
  end

  assign out_ch.valid = out_valid_r;

  // Checks
  a_cook_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cooking |-> state_r.phase == PH_READY)
    else $error("cooking flag set outside ready phase");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.seconds <= SecLimit)
    else $error("second count out of range");

  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.minutes <= MinCap)
    else $error("minute count out of range");

  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after step");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without a step");

endmodule
`default_nettype wire

// ----- verif/tb_oven_cook_timer_controller.sv -----
`default_nettype none
module tb_oven_cook_timer_controller;
  import oct_pkg::*;

  localparam logic [KeyW-1:0] KEY_NONE = 4'd0;
  localparam int HOLD_OFF_CYCLES = 120;

  // Expected status of one transfer on the result channel
  typedef struct packed {
    phase_t           phase;
    logic             editing_seconds;
    logic [MinW-1:0]  minutes_left;
    logic [SecW-1:0]  seconds_left;
    logic [TempW-1:0] temperature;
    logic [PreW-1:0]  preheat_left;
    logic             fan_on;
    logic             buzzer_on;
  } oven_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [DataW-1:0] cfg_pwdata;
  logic [DataW-1:0] cfg_prdata;
  logic             cfg_pready;

  oct_in_if  in_ch();
  oct_out_if out_ch();

  oven_cook_timer_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow of the limit registers
  logic [MinW-1:0]  lim_max_min   = MaxMinRst;
  logic [TempW-1:0] lim_max_temp  = MaxTempRst;
  logic [PreW-1:0]  lim_preheat   = PreheatRst;
  logic [SecW-1:0]  lim_quick     = QuickRst;
  logic [BuzzW-1:0] lim_buzz      = BuzzRst;

  // Predicted controller state
  phase_t           oven_phase   = PH_HOME;
  logic             oven_sel     = 1'b0;
  logic [MinW-1:0]  oven_min     = '0;
  logic [SecW-1:0]  oven_sec     = '0;
  logic [TempW-1:0] oven_temp    = '0;
  logic [PreW-1:0]  oven_preheat = PreheatRst;
  logic             oven_cooking = 1'b0;
  logic [BuzzW-1:0] oven_buzz    = '0;

  oven_status_t pending_status[$];

  int  err_count      = 0;
  int  keys_sent      = 0;
  int  results_seen   = 0;
  int  settings_used  = 0;
  int  cooks_finished = 0;
  int  preheats_begun = 0;
  bit  tx_idle_en     = 1'b1;
  bit  rx_idle_en     = 1'b1;
  bit  hold_off_req   = 1'b0;

  // Next-state and status for one keypad sample
  function automatic oven_status_t oven_step(input logic [KeyW-1:0] key, input logic tk);
    oven_status_t s;
    logic         finish;
    logic [MinW-1:0] min_lim;
    min_lim = (lim_max_min > MinCap) ? MinCap : lim_max_min;
    finish  = 1'b0;
    case (oven_phase)
      PH_SET_TIME: begin
        if (!oven_sel) begin
          if (key == KEY_INC) begin
            if (oven_min < min_lim) oven_min++;
          end else if (key == KEY_DEC) begin
            if (oven_min > 0) oven_min--;
          end else if (key == KEY_NEXT) begin
            oven_sel = 1'b1;
          end
        end else begin
          if (key == KEY_INC) begin
            if (oven_sec < SecLimit) oven_sec++;
          end else if (key == KEY_DEC) begin
            if (oven_sec > 0) oven_sec--;
          end else if (key == KEY_ENTER) begin
            oven_phase = PH_READY;
          end
        end
      end
      PH_READY: begin
        if (key == KEY_INC) begin
          oven_cooking = 1'b1;
        end else if (key == KEY_NEXT) begin
          oven_cooking = 1'b0;
        end else if (key == KEY_STOP) begin
          oven_cooking = 1'b0;
          oven_min = '0;
          oven_sec = '0;
          oven_sel = 1'b0;
          oven_phase = PH_HOME;
        end
        // countdown with minute borrow
        if (tk && oven_cooking) begin
          if (oven_sec > 0) begin
            oven_sec--;
          end else if (oven_min > 0) begin
            oven_min--;
            oven_sec = SecLimit;
          end else begin
            oven_cooking = 1'b0;
            oven_buzz = lim_buzz;
            oven_phase = PH_DONE;
            cooks_finished++;
          end
        end
      end
      PH_DONE: begin
        if (oven_buzz == 0) begin
          finish = 1'b1;
        end else if (tk) begin
          oven_buzz--;
          if (oven_buzz == 0) finish = 1'b1;
        end
        if (finish) begin
          oven_min = '0;
          oven_sec = '0;
          oven_sel = 1'b0;
          oven_cooking = 1'b0;
          oven_phase = PH_HOME;
        end
      end
      PH_SET_TEMP: begin
        if (key == KEY_INC) begin
          if (oven_temp < lim_max_temp) oven_temp++;
        end else if (key == KEY_DEC) begin
          if (oven_temp > 0) oven_temp--;
        end else if (key == KEY_ENTER) begin
          oven_preheat = (lim_preheat > MinCap) ? MinCap : lim_preheat;
          oven_phase = PH_PREHEAT;
          preheats_begun++;
        end
      end
      PH_PREHEAT: begin
        if (tk) begin
          if (oven_preheat > 0) begin
            oven_preheat--;
          end else begin
            oven_min = '0;
            oven_sec = '0;
            oven_sel = 1'b0;
            oven_phase = PH_SET_TIME;
          end
        end
      end
      default: begin
        // home, and any stray phase value
        oven_phase = PH_HOME;
        if (key == KEY_MICRO) begin
          oven_phase = PH_SET_TIME;
        end else if (key == KEY_GRILL) begin
          oven_min = '0;
          oven_sec = '0;
          oven_sel = 1'b0;
          oven_phase = PH_SET_TIME;
        end else if (key == KEY_CONV) begin
          oven_temp = '0;
          oven_phase = PH_SET_TEMP;
        end else if (key == KEY_QUICK) begin
          oven_min = '0;
          oven_sec = (lim_quick > SecLimit) ? SecLimit : lim_quick;
          oven_cooking = 1'b1;
          oven_phase = PH_READY;
        end
      end
    endcase
    s.phase           = oven_phase;
    s.editing_seconds = (oven_phase == PH_SET_TIME) ? oven_sel : 1'b0;
    s.minutes_left    = oven_min;
    s.seconds_left    = oven_sec;
    s.temperature     = oven_temp;
    s.preheat_left    = oven_preheat;
    s.fan_on          = oven_cooking;
    s.buzzer_on       = (oven_phase == PH_DONE);
    return s;
  endfunction

  // One keypad sample transfer; valid stays high after the transfer
  task automatic send_key(input logic [KeyW-1:0] key, input logic tk);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 99) >= 75)
      gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 25);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.key_code <= key;
    in_ch.tick     <= tk;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_status.push_back(oven_step(key, tk));
    keys_sent++;
  endtask

  // Intended key, sometimes preceded by a stray one
  task automatic send_mixed(input logic [KeyW-1:0] key);
    if ($urandom_range(0, 99) < 6)
      send_key(KeyW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    send_key(key, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup then access; psel is left high for back-to-back writes
  task automatic cfg_write(input logic [2:0] idx, input logic [DataW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    case (idx)
      REG_MAX_MIN:  lim_max_min  = val[MinW-1:0];
      REG_MAX_TEMP: lim_max_temp = val[TempW-1:0];
      REG_PREHEAT:  lim_preheat  = val[PreW-1:0];
      REG_QUICK:    lim_quick    = val[SecW-1:0];
      REG_BUZZ:     lim_buzz     = val[BuzzW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [DataW-1:0] max_min, input logic [DataW-1:0] max_temp,
                            input logic [DataW-1:0] preheat, input logic [DataW-1:0] quick,
                            input logic [DataW-1:0] buzz);
    cfg_write(REG_MAX_MIN, max_min);
    cfg_write(REG_MAX_TEMP, max_temp);
    cfg_write(REG_PREHEAT, preheat);
    cfg_write(REG_QUICK, quick);
    cfg_write(REG_BUZZ, buzz);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Walk the controller back to home from wherever it is
  task automatic return_home();
    while (oven_phase != PH_HOME) begin
      case (oven_phase)
        PH_SET_TIME: send_key(oven_sel ? KEY_ENTER : KEY_NEXT, 1'b0);
        PH_READY:    send_key(KEY_STOP, 1'b0);
        PH_SET_TEMP: send_key(KEY_ENTER, 1'b0);
        default:     send_key(KEY_NONE, 1'b1);
      endcase
    end
  endtask

  // Countdown with pause/resume/stop mixed in, then the buzzer
  task automatic run_cook(input int limit);
    int i;
    int r;
    logic [KeyW-1:0] k;
    i = 0;
    while (oven_phase == PH_READY && i < limit) begin
      r = $urandom_range(0, 99);
      if (!oven_cooking && r < 30) k = KEY_INC;
      else if (r < 80) k = KEY_NONE;
      else if (r < 86) k = KEY_NEXT;
      else if (r < 88) k = KEY_STOP;
      else k = KeyW'($urandom_range(0, 15));
      send_key(k, $urandom_range(0, 99) < 60);
      i++;
    end
    while (oven_phase == PH_DONE)
      send_key(($urandom_range(0, 4) == 0) ? KeyW'($urandom_range(0, 15)) : KEY_NONE,
               $urandom_range(0, 99) < 60);
  endtask

  task automatic enter_time_and_cook(input bit deep);
    int n;
    n = deep ? 102 : (($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2));
    repeat (n) send_mixed((deep || $urandom_range(0, 99) < 80) ? KEY_INC : KEY_DEC);
    send_mixed(KEY_NEXT);
    n = deep ? 62 : $urandom_range(0, 8);
    repeat (n) send_mixed((deep || $urandom_range(0, 99) < 80) ? KEY_INC : KEY_DEC);
    if (deep) send_mixed(KEY_DEC);
    send_mixed(KEY_ENTER);
    if ($urandom_range(0, 9) != 0) send_mixed(KEY_INC);
    run_cook(deep ? 40 : 200);
  endtask

  task automatic session_time(input bit deep);
    send_mixed(($urandom_range(0, 1) != 0) ? KEY_MICRO : KEY_GRILL);
    enter_time_and_cook(deep);
    return_home();
  endtask

  task automatic session_conv(input bit deep);
    int n;
    int i;
    send_mixed(KEY_CONV);
    n = deep ? int'(lim_max_temp) + 3 : $urandom_range(0, 6);
    repeat (n) send_mixed((deep || $urandom_range(0, 99) < 80) ? KEY_INC : KEY_DEC);
    send_mixed(KEY_ENTER);
    i = 0;
    while (oven_phase == PH_PREHEAT && i < 300) begin
      send_key(($urandom_range(0, 9) == 0) ? KeyW'($urandom_range(0, 15)) : KEY_NONE,
               $urandom_range(0, 99) < 60);
      i++;
    end
    if (oven_phase == PH_SET_TIME) enter_time_and_cook(1'b0);
    return_home();
  endtask

  task automatic session_quick();
    send_mixed(KEY_QUICK);
    run_cook(200);
    return_home();
  endtask

  task automatic session_noise();
    repeat ($urandom_range(5, 20))
      send_key(KeyW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    return_home();
  endtask

  task automatic run_random(input int items);
    int target;
    int r;
    target = keys_sent + items;
    while (keys_sent < target) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 5) session_time(1'b1);
      else if (r < 35) session_time(1'b0);
      else if (r < 60) session_conv(1'b0);
      else if (r < 80) session_quick();
      else session_noise();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hand-picked walk through every phase at reset limits
  task automatic test_directed();
    send_key(KEY_NONE, 1'b0);
    send_key(4'd15, 1'b1);
    send_key(4'd13, 1'b0);
    send_key(KEY_MICRO, 1'b0);
    send_key(KEY_INC, 1'b1);
    send_key(KEY_INC, 1'b0);
    send_key(KEY_DEC, 1'b0);
    send_key(KEY_NEXT, 1'b0);
    send_key(KEY_DEC, 1'b0);
    send_key(KEY_INC, 1'b0);
    send_key(4'd14, 1'b1);
    send_key(KEY_ENTER, 1'b0);
    send_key(KEY_INC, 1'b1);
    send_key(KEY_NEXT, 1'b1);
    send_key(KEY_INC, 1'b1);
    send_key(KEY_STOP, 1'b1);
    send_key(KEY_GRILL, 1'b0);
    send_key(KEY_NEXT, 1'b0);
    send_key(KEY_INC, 1'b0);
    send_key(KEY_ENTER, 1'b0);
    send_key(KEY_INC, 1'b1);
    send_key(KEY_NONE, 1'b1);
    send_key(KEY_STOP, 1'b1);
    send_key(KEY_NONE, 1'b0);
    send_key(KEY_NONE, 1'b1);
    send_key(KEY_NONE, 1'b1);
    send_key(KEY_QUICK, 1'b0);
    send_key(KEY_STOP, 1'b0);
    send_key(KEY_CONV, 1'b0);
    send_key(KEY_DEC, 1'b0);
    send_key(KEY_INC, 1'b0);
    send_key(KEY_ENTER, 1'b0);
    send_key(KEY_NONE, 1'b1);
    return_home();
  endtask

  // All limits at zero: no minute or temperature increments, instant preheat, zero quick time, no buzzer ticks
  task automatic test_limits_low();
    wait_idle();
    set_limits(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_random(150);
  endtask

  // All bits set: upper bits dropped, limits beyond range capped
  task automatic test_limits_high();
    wait_idle();
    set_limits('1, '1, '1, '1, '1);
    session_time(1'b1);
    session_conv(1'b1);
    session_quick();
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      wait_idle();
      set_limits($urandom_range(0, 5), $urandom_range(0, 12), $urandom_range(0, 6),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 20),
                 $urandom_range(0, 6));
      run_random(100);
    end
  endtask

  // Result side held off while samples keep coming: the pipeline fills and stalls
  task automatic test_backpressure();
    wait_idle();
    set_limits(32'd2, 32'd4, 32'd3, 32'd5, 32'd2);
    tx_idle_en   = 1'b0;
    rx_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    send_key(KEY_QUICK, 1'b0);
    repeat (40) send_key(KeyW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    return_home();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Result-side ready: random stalls, plus one long hold-off on request
  initial begin : status_sink
    int n;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 99) >= 70) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned expv,
                                      input int unsigned got);
    if (expv != got) begin
      $error("%s: expected %0d, got %0d", name, expv, got);
      err_count++;
    end
  endfunction

  // Compare each status transfer with the oldest prediction
  always @(posedge clk) begin : status_monitor
    oven_status_t e;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        $error("status transfer with no prediction pending");
        err_count++;
      end else begin
        e = pending_status.pop_front();
        check_field("phase", 32'(e.phase), 32'(out_ch.phase));
        check_field("editing_seconds", 32'(e.editing_seconds), 32'(out_ch.editing_seconds));
        check_field("minutes_left", 32'(e.minutes_left), 32'(out_ch.minutes_left));
        check_field("seconds_left", 32'(e.seconds_left), 32'(out_ch.seconds_left));
        check_field("temperature", 32'(e.temperature), 32'(out_ch.temperature));
        check_field("preheat_left", 32'(e.preheat_left), 32'(out_ch.preheat_left));
        check_field("fan_on", 32'(e.fan_on), 32'(out_ch.fan_on));
        check_field("buzzer_on", 32'(e.buzzer_on), 32'(out_ch.buzzer_on));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.key_code = KEY_NONE;
    in_ch.tick     = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    rst_n          = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_limits_low();
    test_limits_high();
    test_random_settings();
    test_backpressure();

    wait_idle();
    if (pending_status.size() != 0) begin
      $error("%0d predicted status transfers never arrived", pending_status.size());
      err_count++;
    end
    $display("Sent %0d keypad samples, checked %0d status transfers, %0d limit settings.",
             keys_sent, results_seen, settings_used);
    $display("Cook cycles run to the buzzer: %0d, preheats started: %0d.",
             cooks_finished, preheats_begun);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
